/* rtl/core/bfc_pkg.sv */
// ----------------------------------------------------------------------------
// bfc_pkg
// Shared types and constants of the binary frame checker: sync values,
// status codes and the verdict record passed from front to back.
// ----------------------------------------------------------------------------
package bfc_pkg;

    // frame layout
    localparam logic [7:0]  SYNC_FIRST     = 8'hB5;
    localparam logic [7:0]  SYNC_SECOND    = 8'h62;
    localparam int          COUNT_W        = 17;
    localparam logic [16:0] FRAME_OVERHEAD = 17'd8;
    localparam logic [16:0] COUNT_MAX      = 17'h1FFFF;

    // byte positions of the header fields
    localparam logic [16:0] POS_SYNC0 = 17'd0;
    localparam logic [16:0] POS_SYNC1 = 17'd1;
    localparam logic [16:0] POS_CLASS = 17'd2;
    localparam logic [16:0] POS_ID    = 17'd3;
    localparam logic [16:0] POS_LEN_L = 17'd4;
    localparam logic [16:0] POS_LEN_H = 17'd5;
    localparam logic [16:0] POS_SUM   = 17'd4;

    // verdict codes
    localparam logic [1:0] ST_VALID = 2'd0;
    localparam logic [1:0] ST_LEN   = 2'd1;
    localparam logic [1:0] ST_SYNC  = 2'd2;
    localparam logic [1:0] ST_CSUM  = 2'd3;

    // one verdict per frame
    typedef struct packed {
        logic [15:0] payload_len;
        logic [7:0]  msg_id;
        logic [7:0]  msg_class;
        logic [1:0]  status;
    } t_verdict;

    localparam int VERDICT_W = $bits(t_verdict);

endpackage

/* rtl/core/bfc_front.sv */
// ----------------------------------------------------------------------------
// bfc_front
// Takes one byte a cycle while i_accept is high, tracks header fields and the
// Fletcher-8 sums, and on the last byte of a frame pushes a verdict record into the queue.
// ----------------------------------------------------------------------------
module bfc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_data_byte,
    input  logic              i_frame_end,
    output logic              o_push,
    output bfc_pkg::t_verdict o_verdict
);

    logic [bfc_pkg::COUNT_W-1:0] r_count, n_count;
    logic [7:0]  r_sum_a, n_sum_a;
    logic [7:0]  r_sum_b, n_sum_b;
    logic [7:0]  r_tail0, n_tail0;
    logic [7:0]  r_tail1, n_tail1;
    logic        r_sync_bad, n_sync_bad;
    logic [15:0] r_len, n_len;
    logic [7:0]  r_class, n_class;
    logic [7:0]  r_id, n_id;
    logic [1:0]  status;

    // next frame state for the incoming byte
    always_comb begin
        n_count    = (r_count == bfc_pkg::COUNT_MAX) ? r_count : r_count + 17'd1;
        n_sync_bad = r_sync_bad;
        n_class    = r_class;
        n_id       = r_id;
        n_len      = r_len;
        if (r_count == bfc_pkg::POS_SYNC0 && i_data_byte != bfc_pkg::SYNC_FIRST) begin
            n_sync_bad = 1'b1;
        end
        if (r_count == bfc_pkg::POS_SYNC1 && i_data_byte != bfc_pkg::SYNC_SECOND) begin
            n_sync_bad = 1'b1;
        end
        if (r_count == bfc_pkg::POS_CLASS) begin
            n_class = i_data_byte;
        end
        if (r_count == bfc_pkg::POS_ID) begin
            n_id = i_data_byte;
        end
        if (r_count == bfc_pkg::POS_LEN_L) begin
            n_len = {r_len[15:8], i_data_byte};
        end
        if (r_count == bfc_pkg::POS_LEN_H) begin
            n_len = {i_data_byte, r_len[7:0]};
        end
        // byte two places back enters the sums
        n_sum_a = r_sum_a;
        n_sum_b = r_sum_b;
        if (r_count >= bfc_pkg::POS_SUM) begin
            n_sum_a = r_sum_a + r_tail0;
            n_sum_b = r_sum_b + n_sum_a;
        end
        n_tail0 = r_tail1;
        n_tail1 = i_data_byte;
    end

    // verdict on the last byte, checks in priority order
    always_comb begin
        priority if (n_count < bfc_pkg::FRAME_OVERHEAD) begin
            status = bfc_pkg::ST_LEN;
        end else if (n_sync_bad) begin
            status = bfc_pkg::ST_SYNC;
        end else if ({1'b0, n_len} != n_count - bfc_pkg::FRAME_OVERHEAD) begin
            status = bfc_pkg::ST_LEN;
        end else if (n_tail0 != n_sum_a || n_tail1 != n_sum_b) begin
            status = bfc_pkg::ST_CSUM;
        end else begin
            status = bfc_pkg::ST_VALID;
        end
    end

    assign o_push                = i_accept && i_frame_end;
    assign o_verdict.status      = status;
    assign o_verdict.msg_class   = n_class;
    assign o_verdict.msg_id      = n_id;
    assign o_verdict.payload_len = n_len;

    // frame state, cleared after each verdict
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_count    <= '0;
            r_sum_a    <= '0;
            r_sum_b    <= '0;
            r_tail0    <= '0;
            r_tail1    <= '0;
            r_sync_bad <= 1'b0;
            r_len      <= '0;
            r_class    <= '0;
            r_id       <= '0;
        end else if (i_accept) begin
            r_count    <= n_count;
            r_sum_a    <= n_sum_a;
            r_sum_b    <= n_sum_b;
            r_tail0    <= n_tail0;
            r_tail1    <= n_tail1;
            r_sync_bad <= n_sync_bad;
            r_len      <= n_len;
            r_class    <= n_class;
            r_id       <= n_id;
        end
    end

endmodule

/* rtl/core/bfc_queue.sv */
// ----------------------------------------------------------------------------
// bfc_queue
// Small first-in first-out queue of verdict records between front and back.
// ----------------------------------------------------------------------------
module bfc_queue #(
    parameter int DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  bfc_pkg::t_verdict i_data,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output bfc_pkg::t_verdict o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    bfc_pkg::t_verdict r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

/* rtl/core/bfc_back.sv */
// ----------------------------------------------------------------------------
// bfc_back
// Takes verdict records from the queue, blanks the header fields of a failed
// frame and holds the result word in an output register.
// ----------------------------------------------------------------------------
module bfc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  bfc_pkg::t_verdict i_q_data,
    output logic              o_q_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output bfc_pkg::t_verdict o_result
);

    logic              r_valid;
    bfc_pkg::t_verdict r_result;
    bfc_pkg::t_verdict n_result;

    // fields only reported for a good frame
    always_comb begin
        n_result = i_q_data;
        if (i_q_data.status != bfc_pkg::ST_VALID) begin
            n_result.msg_class   = '0;
            n_result.msg_id      = '0;
            n_result.payload_len = '0;
        end
    end

    assign o_q_pop = i_q_valid && (!r_valid || i_ready);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

/* rtl/core/binary_frame_checker.sv */
// ----------------------------------------------------------------------------
// binary_frame_checker
// Checks sync bytes, declared length and Fletcher-8 checksum of binary frames.
// ----------------------------------------------------------------------------
// Input stream: one frame byte per word on s_axis tdata[7:0], tlast on the
// final byte of a frame. One byte is taken every cycle while tready is high.
// Output stream: one word per frame, sent after its last byte:
// status, class, id and payload length (class, id and length are zero
// unless status is valid). Status: 0 valid, 1 length error, 2 sync error,
// 3 checksum error; checked in the order length too short, sync, length
// field, checksum. Frames longer than 131071 bytes give a length error.
// The verdict is written into the queue as the last byte is taken, then
// moves into the output register. Throughput: one byte per cycle while
// tready is high; the per-byte work is two 8-bit adds.
// A stalled receiver fills the output register and then the verdict queue
// (QUEUE_DEPTH words); tready drops only while that queue is full.
// Reset clears the frame state, the queue and the output register.
// ----------------------------------------------------------------------------
module binary_frame_checker #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tlast,   // frame_end
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata    // [1:0] status, [9:2] msg_class,
                                          // [17:10] msg_id, [33:18] payload_len
);

    logic              accept;
    logic              push;
    logic              q_full;
    logic              q_valid;
    logic              q_pop;
    bfc_pkg::t_verdict front_verdict;
    bfc_pkg::t_verdict q_data;
    bfc_pkg::t_verdict result;

    assign o_s_axis_tready = !q_full;
    assign accept          = i_s_axis_tvalid && !q_full;

    // byte tracking and classification
    bfc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_s_axis_tdata),
        .i_frame_end (i_s_axis_tlast),
        .o_push      (push),
        .o_verdict   (front_verdict)
    );

    // verdict queue
    bfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_verdict),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    // result formatting and output register
    bfc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_result  (result)
    );

    assign o_m_axis_tdata = {6'b0, result.payload_len, result.msg_id,
                             result.msg_class, result.status};

endmodule

/* tb/sv/binary_frame_checker_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_frame_checker_tb
// Streams frame bytes into the checker through a bursty sender and takes the
// verdicts through a receiver that stalls in changing patterns. Each verdict
// is compared field by field with one worked out byte by byte alongside the
// stream: directed corner frames first, then a random mix of good, damaged
// and junk frames.
// ----------------------------------------------------------------------------
module binary_frame_checker_tb;

    // damage applied to a built frame
    localparam logic [4:0] DEF_NONE  = 5'd0;
    localparam logic [4:0] DEF_SYNC0 = 5'd1;
    localparam logic [4:0] DEF_SYNC1 = 5'd2;
    localparam logic [4:0] DEF_LEN   = 5'd4;
    localparam logic [4:0] DEF_CKA   = 5'd8;
    localparam logic [4:0] DEF_CKB   = 5'd16;

    localparam int RANDOM_BYTES = 760;
    localparam int RANDOM_FRAMES = 48;
    localparam int DRAIN_CYCLES = 16;
    localparam int ERR_PRINT_MAX = 40;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_frame_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata = 8'd0;   // [7:0] data_byte
    logic        i_s_axis_tlast = 1'b0;   // frame_end
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [39:0] o_m_axis_tdata;          // [1:0] status, [9:2] msg_class,
                                          // [17:10] msg_id, [33:18] payload_len

    t_frame_word         tx_words[$];
    logic [7:0]          frame_buf[$];
    bfc_pkg::t_verdict   expected_verdicts[$];
    int                  n_err = 0;

    // running frame state of the predictor
    logic [16:0] fr_count = '0;
    logic [7:0]  fr_sum_a = '0;
    logic [7:0]  fr_sum_b = '0;
    logic [7:0]  fr_tail[2] = '{8'd0, 8'd0};
    logic        fr_sync_bad = 1'b0;
    logic [15:0] fr_len = '0;
    logic [7:0]  fr_class = '0;
    logic [7:0]  fr_id = '0;

    // sender burst and receiver stall state
    int tx_burst_left = 0;
    int tx_gap_left = 0;
    int rx_mode = 0;
    int rx_left = 0;
    int rx_tick = 0;

    binary_frame_checker dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // advance the frame state by one byte; returns 1 with the verdict on a last byte
    function automatic bit frame_verdict_step(input logic [7:0] b, input logic last,
                                              output bfc_pkg::t_verdict v);
        logic [16:0] total;
        v = '0;
        if (fr_count == bfc_pkg::POS_SYNC0 && b != bfc_pkg::SYNC_FIRST) fr_sync_bad = 1'b1;
        if (fr_count == bfc_pkg::POS_SYNC1 && b != bfc_pkg::SYNC_SECOND) fr_sync_bad = 1'b1;
        if (fr_count == bfc_pkg::POS_CLASS) fr_class = b;
        if (fr_count == bfc_pkg::POS_ID) fr_id = b;
        if (fr_count == bfc_pkg::POS_LEN_L) fr_len[7:0] = b;
        if (fr_count == bfc_pkg::POS_LEN_H) fr_len[15:8] = b;
        // a byte joins the sums two bytes after it arrives
        if (fr_count >= bfc_pkg::POS_SUM) begin
            fr_sum_a = fr_sum_a + fr_tail[0];
            fr_sum_b = fr_sum_b + fr_sum_a;
        end
        fr_tail[0] = fr_tail[1];
        fr_tail[1] = b;
        if (fr_count != bfc_pkg::COUNT_MAX) fr_count = fr_count + 17'd1;
        if (!last) return 1'b0;

        total = fr_count;
        if (total < bfc_pkg::FRAME_OVERHEAD)
            v.status = bfc_pkg::ST_LEN;
        else if (fr_sync_bad)
            v.status = bfc_pkg::ST_SYNC;
        else if ({1'b0, fr_len} != total - bfc_pkg::FRAME_OVERHEAD)
            v.status = bfc_pkg::ST_LEN;
        else if (fr_tail[0] != fr_sum_a || fr_tail[1] != fr_sum_b)
            v.status = bfc_pkg::ST_CSUM;
        else
            v.status = bfc_pkg::ST_VALID;
        if (v.status == bfc_pkg::ST_VALID) begin
            v.msg_class = fr_class;
            v.msg_id = fr_id;
            v.payload_len = fr_len;
        end

        fr_count = '0;
        fr_sum_a = '0;
        fr_sum_b = '0;
        fr_tail[0] = '0;
        fr_tail[1] = '0;
        fr_sync_bad = 1'b0;
        fr_len = '0;
        fr_class = '0;
        fr_id = '0;
        return 1'b1;
    endfunction

    // random byte leaning towards the extremes
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // move the built frame into the send queue, last flag on the final byte
    function automatic void flush_frame();
        int k;
        for (k = 0; k < frame_buf.size(); k++)
            tx_words.push_back('{data: frame_buf[k], last: (k == frame_buf.size() - 1)});
    endfunction

    // framed message with correct sums, then the requested damage
    function automatic void add_frame(input logic [7:0] cls, input logic [7:0] id,
                                      input int plen, input logic [4:0] defects);
        logic [15:0] lf;
        logic [7:0]  ck_a;
        logic [7:0]  ck_b;
        int k;
        frame_buf.delete();
        lf = plen[15:0];
        if (defects & DEF_LEN) lf = lf + 16'($urandom_range(1, 300));
        frame_buf.push_back(bfc_pkg::SYNC_FIRST);
        frame_buf.push_back(bfc_pkg::SYNC_SECOND);
        frame_buf.push_back(cls);
        frame_buf.push_back(id);
        frame_buf.push_back(lf[7:0]);
        frame_buf.push_back(lf[15:8]);
        for (k = 0; k < plen; k++) frame_buf.push_back(pick_byte());
        ck_a = '0;
        ck_b = '0;
        for (k = 2; k < frame_buf.size(); k++) begin
            ck_a = ck_a + frame_buf[k];
            ck_b = ck_b + ck_a;
        end
        frame_buf.push_back(ck_a);
        frame_buf.push_back(ck_b);
        if (defects & DEF_SYNC0) frame_buf[0] ^= 8'($urandom_range(1, 255));
        if (defects & DEF_SYNC1) frame_buf[1] ^= 8'($urandom_range(1, 255));
        if (defects & DEF_CKA) frame_buf[frame_buf.size() - 2] ^= 8'($urandom_range(1, 255));
        if (defects & DEF_CKB) frame_buf[frame_buf.size() - 1] ^= 8'($urandom_range(1, 255));
        flush_frame();
    endfunction

    // unframed junk, optionally led by the sync pair
    function automatic void add_junk(input int n, input bit lead_sync);
        int k;
        frame_buf.delete();
        for (k = 0; k < n; k++) frame_buf.push_back(pick_byte());
        if (lead_sync) frame_buf[0] = bfc_pkg::SYNC_FIRST;
        if (lead_sync && n > 1) frame_buf[1] = bfc_pkg::SYNC_SECOND;
        flush_frame();
    endfunction

    // sender: bursts of words with random gaps, prediction on every accepted word
    always @(posedge i_clk) begin : byte_sender
        bfc_pkg::t_verdict v;
        t_frame_word       w;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                if (frame_verdict_step(i_s_axis_tdata, i_s_axis_tlast, v))
                    expected_verdicts.push_back(v);
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (tx_gap_left > 0) begin
                    tx_gap_left--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (tx_words.size() != 0) begin
                    w = tx_words.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata <= w.data;
                    i_s_axis_tlast <= w.last;
                    if (tx_burst_left <= 1) begin
                        tx_burst_left = $urandom_range(1, 48);
                        tx_gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
                    end else begin
                        tx_burst_left--;
                    end
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: ready pattern switches between four modes at random
    always @(posedge i_clk) begin : verdict_receiver
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(20, 200);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            0: i_m_axis_tready <= 1'b1;
            1: i_m_axis_tready <= 1'($urandom_range(0, 1));
            2: i_m_axis_tready <= (rx_tick % 8 == 0);
            default: i_m_axis_tready <= ($urandom_range(0, 3) != 0);
        endcase
        rx_tick++;
    end

    function automatic void report_mismatch(input string field, input int want, input int got);
        n_err++;
        if (n_err <= ERR_PRINT_MAX)
            $error("%s: expected %0h, got %0h", field, want, got);
    endfunction

    // monitor: compare each taken verdict with the oldest prediction
    always @(posedge i_clk) begin : verdict_monitor
        bfc_pkg::t_verdict got;
        bfc_pkg::t_verdict want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata[bfc_pkg::VERDICT_W-1:0];
            if (expected_verdicts.size() == 0) begin
                n_err++;
                if (n_err <= ERR_PRINT_MAX) $error("verdict with none pending: %h", o_m_axis_tdata);
            end else begin
                want = expected_verdicts.pop_front();
                if (got.status != want.status)
                    report_mismatch("status", int'(want.status), int'(got.status));
                if (got.msg_class != want.msg_class)
                    report_mismatch("msg_class", int'(want.msg_class), int'(got.msg_class));
                if (got.msg_id != want.msg_id)
                    report_mismatch("msg_id", int'(want.msg_id), int'(got.msg_id));
                if (got.payload_len != want.payload_len)
                    report_mismatch("payload_len", int'(want.payload_len),
                                    int'(got.payload_len));
                if (o_m_axis_tdata[39:bfc_pkg::VERDICT_W] != '0)
                    report_mismatch("tdata padding", 0,
                                    int'(o_m_axis_tdata[39:bfc_pkg::VERDICT_W]));
            end
        end
    end

    // stimulus and end of run
    initial begin : stimulus
        int start;
        int frames;
        int plen;
        int pick;
        logic [4:0] defects;

        // directed corners
        add_junk(1, 1'b1);                                  // one byte frame
        add_junk(7, 1'b1);                                  // just short of the shortest frame
        add_junk(5, 1'b0);                                  // short and unsynced
        add_frame(8'h00, 8'h00, 0, DEF_NONE);               // empty payload
        add_frame(8'hFF, 8'hFF, 4, DEF_NONE);
        add_frame(8'h01, 8'h07, 3, DEF_SYNC0);
        add_frame(8'h01, 8'h07, 3, DEF_SYNC1);
        add_frame(8'h0A, 8'h33, 2, DEF_LEN);
        add_frame(8'h0A, 8'h33, 2, DEF_CKA);
        add_frame(8'h0A, 8'h33, 2, DEF_CKB);
        add_frame(8'h02, 8'h15, 1, DEF_SYNC0 | DEF_LEN);    // sync beats length
        add_frame(8'h02, 8'h15, 1, DEF_LEN | DEF_CKB);      // length beats checksum
        add_frame(8'h05, 8'h01, 0, DEF_SYNC1 | DEF_CKA);    // sync beats checksum
        add_frame(8'hFF, 8'h00, 5, DEF_NONE);
        add_frame(8'h10, 8'h20, 6, DEF_NONE);

        // random mix, mostly well formed
        start = tx_words.size();
        frames = 0;
        while (tx_words.size() - start < RANDOM_BYTES || frames < RANDOM_FRAMES) begin
            pick = $urandom_range(0, 99);
            plen = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 300) : $urandom_range(0, 24);
            if (pick < 65) begin
                add_frame(pick_byte(), pick_byte(), plen, DEF_NONE);
            end else if (pick < 88) begin
                defects = 5'(1 << $urandom_range(0, 4));
                if ($urandom_range(0, 3) == 0) defects |= 5'(1 << $urandom_range(0, 4));
                add_frame(pick_byte(), pick_byte(), plen, defects);
            end else begin
                add_junk($urandom_range(1, 12), 1'($urandom_range(0, 1)));
            end
            frames++;
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (tx_words.size() != 0 || i_s_axis_tvalid || expected_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_err == 0)
            $display("binary_frame_checker_tb OK");
        else
            $display("binary_frame_checker_tb NOT OK");
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #2_000_000;
        $display("binary_frame_checker_tb NOT OK");
        $finish;
    end

endmodule
